// ----- design/scad_pkg.sv -----
// shared types and constants of the serial can adapter deframer
// no dependencies; imported by every other file of the block
`default_nettype none

package scad_pkg;

   // framing bytes
   localparam logic [7:0] SYNC_BYTE     = 8'hAA;
   localparam logic [7:0] CMD_HEADER    = 8'h55;
   localparam logic [3:0] DATA_NIBBLE   = 4'hC;

   // frame geometry
   localparam int unsigned CMD_LEN       = 20;
   localparam int unsigned DATA_OVERHEAD = 5;
   localparam int unsigned PAYLOAD_LANES = 8;
   localparam int unsigned ID_LOW_POS    = 2;
   localparam int unsigned ID_HIGH_POS   = 3;
   localparam int unsigned FIRST_DATA_POS = 4;

   localparam logic [4:0] CMD_LAST_POS  = 5'(CMD_LEN - 1);

   // result codes
   typedef enum logic [2:0] {
      KIND_SKIP    = 3'd0,
      KIND_UNKNOWN = 3'd1,
      KIND_DATA    = 3'd2,
      KIND_CMD_OK  = 3'd3,
      KIND_CMD_BAD = 3'd4
   } frame_kind_type;

   // one result item
   typedef struct packed {
      frame_kind_type frame_kind;
      logic [15:0]    frame_id;
      logic [3:0]     data_length;
      logic [63:0]    payload;
   } result_type;

   // what the parser hands to the result buffer for one byte
   typedef struct packed {
      logic       has_result;
      result_type result;
   } parse_out_type;

endpackage

`default_nettype wire

// ----- design/scad_req_if.sv -----
// input channel of the deframer: one received serial byte per item
// depends on scad_pkg
`default_nettype none

interface scad_req_if;
   import scad_pkg::*;

   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink   (input valid, input rx_byte, output ready);

endinterface

`default_nettype wire

// ----- design/scad_rsp_if.sv -----
// result channel of the deframer: one item per completed frame, unknown header or skipped byte
// depends on scad_pkg
`default_nettype none

interface scad_rsp_if;
   import scad_pkg::*;

   logic           valid;
   logic           ready;
   frame_kind_type frame_kind;
   logic [15:0]    frame_id;
   logic [3:0]     data_length;
   logic [63:0]    payload;

   modport source (output valid, output frame_kind, output frame_id,
                   output data_length, output payload, input ready);
   modport sink   (input valid, input frame_kind, input frame_id,
                   input data_length, input payload, output ready);

endinterface

`default_nettype wire

// ----- design/serial_can_adapter_deframer.sv -----
// Serial CAN adapter deframer, top level.
// One req_port item carries one byte received from the serial link. Bytes
// are reassembled into adapter frames (0xAA sync, then a header byte); one
// rsp_port item is given per completed frame, one per unknown header byte,
// and one per byte that arrives while no frame is open and is not 0xAA.
// Bytes that only advance a frame give no item.
// A byte in the input register is decoded combinationally and its result
// is written into the result buffer when that has room.
// Throughput: one byte per cycle while the buffer has room; the state update
// is a compare and an 8-bit add between the input and frame state registers.
// A two-entry result buffer (output register plus skid) parts the channels:
// while the receiver stalls, up to two results and one byte in the input
// register are held, and req_port.ready drops only when all are occupied.
// Reset (synchronous, active high) closes any open frame, empties the input
// register and the result buffer; no item is lost or invented afterwards.
// depends on scad_pkg, scad_req_if, scad_rsp_if, scad_parser, scad_rsp_buffer
`default_nettype none

module serial_can_adapter_deframer (
   input  wire        clock,
   input  wire        reset,
   scad_req_if.sink   req_port,
   scad_rsp_if.source rsp_port
);
   import scad_pkg::*;

   logic          in_valid_ff, in_valid_in;
   logic [7:0]    in_byte_ff;
   logic          advance;
   logic          buf_full;
   parse_out_type parse_out;
   result_type    out_data;
   logic          out_valid;
   logic          req_take;

   // input register moves on whenever the result buffer has room
   assign advance        = in_valid_ff & ~buf_full;
   assign req_port.ready = ~in_valid_ff | ~buf_full;
   assign req_take       = req_port.valid & req_port.ready;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_take) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_byte_ff <= req_port.rx_byte;
      end
   end

   scad_parser u_parser (
      .clock      (clock),
      .reset      (reset),
      .byte_valid (advance),
      .byte_data  (in_byte_ff),
      .parse_out  (parse_out)
   );

   scad_rsp_buffer u_rsp_buffer (
      .clock     (clock),
      .reset     (reset),
      .push      (advance & parse_out.has_result),
      .push_data (parse_out.result),
      .full      (buf_full),
      .out_valid (out_valid),
      .out_ready (rsp_port.ready),
      .out_data  (out_data)
   );

   // result channel
   assign rsp_port.valid       = out_valid;
   assign rsp_port.frame_kind  = out_data.frame_kind;
   assign rsp_port.frame_id    = out_data.frame_id;
   assign rsp_port.data_length = out_data.data_length;
   assign rsp_port.payload     = out_data.payload;

`ifndef ASSERT_OFF
   a_held_byte_waits: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && buf_full |=> in_valid_ff && $stable(in_byte_ff))
      else $error("held byte lost while result buffer full");
`endif

endmodule

`default_nettype wire

// ----- design/scad_parser.sv -----
// frame state of the deframer and the per-byte decode
// depends on scad_pkg
`default_nettype none

module scad_parser (
   input  wire                     clock,
   input  wire                     reset,
   input  wire                     byte_valid,
   input  wire  [7:0]              byte_data,
   output scad_pkg::parse_out_type parse_out
);
   import scad_pkg::*;

   logic [4:0]  byte_count_ff, byte_count_in;
   logic [7:0]  header_ff, header_in;
   logic [15:0] ident_ff, ident_in;
   logic [63:0] payload_ff, payload_in;
   logic [7:0]  sum_ff, sum_in;
   logic [4:0]  data_last;
   logic        is_data_header;

   assign data_last      = {1'b0, header_ff[3:0]} + 5'(DATA_OVERHEAD - 1);
   assign is_data_header = (byte_data[7:4] == DATA_NIBBLE);

   // decode one byte against the open frame
   always_comb begin
      byte_count_in = byte_count_ff;
      header_in     = header_ff;
      ident_in      = ident_ff;
      payload_in    = payload_ff;
      sum_in        = sum_ff;
      parse_out     = '0;
      parse_out.result.frame_kind = KIND_SKIP;

      priority if (byte_count_ff == 5'd0) begin
         // waiting for sync
         if (byte_data != SYNC_BYTE) begin
            parse_out.has_result = 1'b1;
         end else begin
            byte_count_in = 5'd1;
         end
      end else if (byte_count_ff == 5'd1) begin
         // header byte
         if (byte_data == CMD_HEADER || is_data_header) begin
            header_in     = byte_data;
            byte_count_in = 5'd2;
         end else begin
            byte_count_in = '0;
            header_in     = '0;
            parse_out.has_result        = 1'b1;
            parse_out.result.frame_kind = KIND_UNKNOWN;
         end
      end else if (header_ff == CMD_HEADER) begin
         // command frame: sum bytes, last byte is the checksum
         if (byte_count_ff < CMD_LAST_POS) begin
            sum_in        = sum_ff + byte_data;
            byte_count_in = byte_count_ff + 5'd1;
         end else begin
            byte_count_in = '0;
            header_in     = '0;
            sum_in        = '0;
            parse_out.has_result        = 1'b1;
            parse_out.result.frame_kind = (sum_ff == byte_data) ? KIND_CMD_OK : KIND_CMD_BAD;
         end
      end else begin
         // data frame
         if (byte_count_ff >= data_last) begin
            byte_count_in = '0;
            header_in     = '0;
            ident_in      = '0;
            payload_in    = '0;
            parse_out.has_result         = 1'b1;
            parse_out.result.frame_kind  = KIND_DATA;
            parse_out.result.frame_id    = ident_ff;
            parse_out.result.data_length = header_ff[3:0];
            parse_out.result.payload     = payload_ff;
         end else begin
            if (byte_count_ff == 5'(ID_LOW_POS)) begin
               ident_in[7:0] = byte_data;
            end
            if (byte_count_ff == 5'(ID_HIGH_POS)) begin
               ident_in[15:8] = byte_data;
            end
            // each data byte lands in its own lane, later ones are dropped
            for (int i = 0; i < PAYLOAD_LANES; i++) begin
               if (byte_count_ff == 5'(i + FIRST_DATA_POS)) begin
                  payload_in[8*i +: 8] = byte_data;
               end
            end
            byte_count_in = byte_count_ff + 5'd1;
         end
      end
   end

   // frame state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         byte_count_ff <= '0;
         header_ff     <= '0;
         ident_ff      <= '0;
         payload_ff    <= '0;
         sum_ff        <= '0;
      end else if (byte_valid) begin
         byte_count_ff <= byte_count_in;
         header_ff     <= header_in;
         ident_ff      <= ident_in;
         payload_ff    <= payload_in;
         sum_ff        <= sum_in;
      end
   end

`ifndef ASSERT_OFF
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      byte_count_ff <= CMD_LAST_POS)
      else $error("byte count beyond longest frame");
   a_open_has_header: assert property (@(posedge clock) disable iff (reset)
      byte_count_ff >= 5'd2 |-> (header_ff == CMD_HEADER || header_ff[7:4] == DATA_NIBBLE))
      else $error("open frame without a known header");
`endif

endmodule

`default_nettype wire

// ----- design/scad_rsp_buffer.sv -----
// two-entry result buffer: output register plus skid register
// depends on scad_pkg
`default_nettype none

module scad_rsp_buffer (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  push,
   input  scad_pkg::result_type push_data,
   output logic                 full,
   output logic                 out_valid,
   input  wire                  out_ready,
   output scad_pkg::result_type out_data
);
   import scad_pkg::*;

   logic       main_valid_ff, main_valid_in;
   logic       skid_valid_ff, skid_valid_in;
   result_type main_ff, main_in;
   result_type skid_ff, skid_in;
   logic       pop;

   assign pop       = main_valid_ff & out_ready;
   assign full      = main_valid_ff & skid_valid_ff;
   assign out_valid = main_valid_ff;
   assign out_data  = main_ff;

   // head moves up from skid on a pop, new items fill the first free slot
   always_comb begin
      main_valid_in = main_valid_ff;
      skid_valid_in = skid_valid_ff;
      main_in       = main_ff;
      skid_in       = skid_ff;
      if (pop) begin
         if (skid_valid_ff) begin
            main_in       = skid_ff;
            main_valid_in = 1'b1;
            skid_valid_in = push;
            skid_in       = push_data;
         end else begin
            main_valid_in = push;
            main_in       = push_data;
         end
      end else if (push) begin
         if (!main_valid_ff) begin
            main_valid_in = 1'b1;
            main_in       = push_data;
         end else begin
            skid_valid_in = 1'b1;
            skid_in       = push_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         main_valid_ff <= main_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   // payload registers carry no reset
   always_ff @(posedge clock) begin
      main_ff <= main_in;
      skid_ff <= skid_in;
   end

`ifndef ASSERT_OFF
   a_skid_behind_main: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> main_valid_ff)
      else $error("skid entry held with empty output register");
   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      full |-> !push)
      else $error("item pushed into full result buffer");
`endif

endmodule

`default_nettype wire

// ----- bench/serial_can_adapter_deframer_tb.sv -----
// testbench of the serial can adapter deframer: byte stream in, frame results out
// a shadow frame parser predicts every result; depends on scad_pkg, scad_req_if,
// scad_rsp_if and serial_can_adapter_deframer
`default_nettype none

module serial_can_adapter_deframer_tb;
   import scad_pkg::*;

   localparam int unsigned RANDOM_ITEMS  = 1250;
   localparam int unsigned SEGMENT_ITEMS = 250;
   localparam int unsigned IDLE_LIMIT    = 2000;
   localparam int unsigned SETTLE_CYCLES = 8;
   localparam int unsigned MAX_REPORTS   = 10;

   logic clock = 1'b0;
   logic reset = 1'b1;

   scad_req_if req_bus ();
   scad_rsp_if rsp_bus ();

   serial_can_adapter_deframer uut (
      .clock    (clock),
      .reset    (reset),
      .req_port (req_bus),
      .rsp_port (rsp_bus)
   );

   // shadow copy of the frame state
   logic [4:0]  shadow_count   = '0;
   logic [7:0]  shadow_header  = '0;
   logic [15:0] shadow_ident   = '0;
   logic [63:0] shadow_payload = '0;
   logic [7:0]  shadow_sum     = '0;

   result_type  pending_frames[$];

   int unsigned mismatch_count = 0;
   int unsigned bytes_sent     = 0;
   int unsigned idle_cycles    = 0;
   int unsigned burst_left     = 0;
   bit          sender_gaps     = 1'b1;
   bit          receiver_stalls = 1'b1;

   always #2 clock = ~clock;

   // close the open frame
   function automatic void clear_frame();
      shadow_count   = '0;
      shadow_header  = '0;
      shadow_ident   = '0;
      shadow_payload = '0;
      shadow_sum     = '0;
   endfunction

   function automatic void push_frame(frame_kind_type kind, logic [15:0] id,
                                      logic [3:0] len, logic [63:0] pay);
      result_type r;
      r.frame_kind  = kind;
      r.frame_id    = id;
      r.data_length = len;
      r.payload     = pay;
      pending_frames.push_back(r);
   endfunction

   // advance the shadow parser by one received byte
   function automatic void decode_byte(logic [7:0] b);
      int unsigned    pos;
      int unsigned    last_pos;
      logic [3:0]     dlc;
      frame_kind_type kind;
      pos      = 32'(shadow_count);
      dlc      = shadow_header[3:0];
      last_pos = 32'(dlc) + DATA_OVERHEAD - 1;
      if (pos == 0) begin
         if (b != SYNC_BYTE) begin
            push_frame(KIND_SKIP, '0, '0, '0);
         end else begin
            clear_frame();
            shadow_count = 5'd1;
         end
      end else if (pos == 1) begin
         shadow_header = b;
         if (b == CMD_HEADER || b[7:4] == DATA_NIBBLE) begin
            shadow_count = 5'd2;
         end else begin
            clear_frame();
            push_frame(KIND_UNKNOWN, '0, '0, '0);
         end
      end else if (shadow_header == CMD_HEADER) begin
         // command frame: sum bytes 2..18, compare with byte 19
         if (pos < CMD_LEN - 1) begin
            shadow_sum   = shadow_sum + b;
            shadow_count = 5'(pos + 1);
         end else begin
            kind = (shadow_sum == b) ? KIND_CMD_OK : KIND_CMD_BAD;
            clear_frame();
            push_frame(kind, '0, '0, '0);
         end
      end else if (pos >= last_pos) begin
         // trailing byte closes the data frame unchecked
         push_frame(KIND_DATA, shadow_ident, dlc, shadow_payload);
         clear_frame();
      end else begin
         if (pos == ID_LOW_POS) begin
            shadow_ident[7:0] = b;
         end else if (pos == ID_HIGH_POS) begin
            shadow_ident[15:8] = b;
         end else if (pos < FIRST_DATA_POS + PAYLOAD_LANES) begin
            shadow_payload[8 * (pos - FIRST_DATA_POS) +: 8] = b;
         end
         shadow_count = 5'(pos + 1);
      end
   endfunction

   // predict on every accepted byte, check every accepted result
   always @(posedge clock) begin : result_check
      result_type want;
      result_type got;
      if (!reset) begin
         if (req_bus.valid && req_bus.ready) decode_byte(req_bus.rx_byte);
         if (rsp_bus.valid && rsp_bus.ready) begin
            got.frame_kind  = rsp_bus.frame_kind;
            got.frame_id    = rsp_bus.frame_id;
            got.data_length = rsp_bus.data_length;
            got.payload     = rsp_bus.payload;
            if (pending_frames.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= MAX_REPORTS)
                  $display("unexpected item: kind %0d id %h len %0d payload %h",
                           got.frame_kind, got.frame_id, got.data_length, got.payload);
            end else begin
               want = pending_frames.pop_front();
               if (want !== got) begin
                  mismatch_count++;
                  if (mismatch_count <= MAX_REPORTS) begin
                     $display("mismatch: exp kind %0d id %h len %0d payload %h",
                              want.frame_kind, want.frame_id, want.data_length,
                              want.payload);
                     $display("          act kind %0d id %h len %0d payload %h",
                              got.frame_kind, got.frame_id, got.data_length,
                              got.payload);
                  end
               end
            end
         end
      end
   end

   // watchdog on cycles with no item moving on either channel
   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
         end
      end
   end

   // receiver: rotating stall mask, reloaded now and then, never all zero
   initial begin : receiver
      logic [15:0] stall_mask;
      int unsigned mask_age;
      stall_mask    = 16'hFFFF;
      mask_age      = 0;
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (mask_age == 0) begin
            stall_mask = ($urandom_range(0, 3) == 0) ? 16'hFFFF : (16'($urandom) | 16'h0001);
            mask_age   = $urandom_range(16, 96);
         end
         mask_age--;
         rsp_bus.ready = !receiver_stalls || stall_mask[0];
         stall_mask    = {stall_mask[0], stall_mask[15:1]};
      end
   end

   // send one byte; bursts of random length with random gaps between them while sender_gaps is set
   task automatic send_byte(input logic [7:0] value);
      int unsigned gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         if (sender_gaps) begin
            gap = $urandom_range(1, 6);
            req_bus.valid   = 1'b0;
            req_bus.rx_byte = 8'($urandom);
            repeat (gap) @(negedge clock);
         end
      end
      req_bus.valid   = 1'b1;
      req_bus.rx_byte = value;
      do @(posedge clock); while (!req_bus.ready);
      @(negedge clock);
      burst_left--;
      bytes_sent++;
   endtask

   // hold the sender until every expected result is in
   task automatic drain_results();
      req_bus.valid = 1'b0;
      while (pending_frames.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic send_std_frame(input logic [3:0] dlc);
      send_byte(SYNC_BYTE);
      send_byte({DATA_NIBBLE, dlc});
      send_byte(8'($urandom));
      send_byte(8'($urandom));
      repeat (dlc) send_byte(8'($urandom));
      send_byte(8'($urandom));
   endtask

   task automatic send_command_frame(input bit good_sum);
      logic [7:0] sum;
      logic [7:0] b;
      sum = '0;
      send_byte(SYNC_BYTE);
      send_byte(CMD_HEADER);
      repeat (CMD_LEN - 3) begin
         b   = 8'($urandom);
         sum = sum + b;
         send_byte(b);
      end
      send_byte(good_sum ? sum : (sum ^ 8'($urandom_range(1, 255))));
   endtask

   task automatic test_unsynced_bytes();
      send_byte(8'h00);
      send_byte(8'hFF);
   endtask

   task automatic test_unknown_header();
      send_byte(SYNC_BYTE);
      send_byte(8'h00);
      // sync byte in header position is just another unknown header
      send_byte(SYNC_BYTE);
      send_byte(SYNC_BYTE);
   endtask

   task automatic test_empty_data_frame();
      send_byte(SYNC_BYTE);
      send_byte({DATA_NIBBLE, 4'h0});
      send_byte(8'hFF);
      send_byte(8'h00);
      send_byte(SYNC_BYTE);
   endtask

   task automatic test_long_data_frame();
      // nine data bytes: the ninth is dropped from the payload
      send_byte(SYNC_BYTE);
      send_byte({DATA_NIBBLE, 4'h9});
      send_byte(8'h00);
      send_byte(8'hFF);
      for (int i = 0; i < 8; i++) send_byte(i[0] ? 8'h00 : 8'hFF);
      send_byte(8'h5A);
      send_byte(CMD_HEADER);
      drain_results();
   endtask

   task automatic test_random_stream();
      int unsigned stop_at;
      int unsigned segment_end;
      int unsigned segment;
      int unsigned pick;
      logic [7:0]  b;
      stop_at     = bytes_sent + RANDOM_ITEMS;
      segment     = 0;
      segment_end = bytes_sent + SEGMENT_ITEMS;
      while (bytes_sent < stop_at) begin
         // new idling mode per segment, sometimes with a full drain first
         if (bytes_sent >= segment_end) begin
            segment++;
            segment_end = bytes_sent + SEGMENT_ITEMS;
            if (segment[0]) drain_results();
            sender_gaps     = (segment % 4 == 0) || (segment % 4 == 2);
            receiver_stalls = (segment % 4 == 0) || (segment % 4 == 1);
         end
         pick = $urandom_range(0, 99);
         if (pick < 35) begin
            send_std_frame(($urandom_range(0, 4) == 0) ? 4'($urandom_range(9, 15))
                                                      : 4'($urandom_range(0, 8)));
         end else if (pick < 65) begin
            send_command_frame(1'($urandom_range(0, 1)));
         end else if (pick < 75) begin
            do b = 8'($urandom); while (b == CMD_HEADER || b[7:4] == DATA_NIBBLE);
            send_byte(SYNC_BYTE);
            send_byte(b);
         end else if (pick < 85) begin
            repeat ($urandom_range(1, 4)) begin
               do b = 8'($urandom); while (b == SYNC_BYTE);
               send_byte(b);
            end
         end else begin
            // raw noise, may leave a frame half open
            repeat ($urandom_range(1, 10)) send_byte(8'($urandom));
         end
      end
      sender_gaps     = 1'b1;
      receiver_stalls = 1'b1;
   endtask

   // test sequence
   initial begin : run_tests
      req_bus.valid   = 1'b0;
      req_bus.rx_byte = 8'h00;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      test_unsynced_bytes();
      test_unknown_header();
      test_empty_data_frame();
      test_long_data_frame();
      test_random_stream();
      drain_results();
      if (mismatch_count == 0 && pending_frames.size() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

`default_nettype wire

// ----- sim.f -----
design/scad_pkg.sv
design/scad_req_if.sv
design/scad_rsp_if.sv
design/scad_parser.sv
design/scad_rsp_buffer.sv
design/serial_can_adapter_deframer.sv
bench/serial_can_adapter_deframer_tb.sv
